>>> hw/rtl/sprite_quad_expander_macros.svh
// Assertion macros for the sprite quad expander RTL.
`ifndef SPRITE_QUAD_EXPANDER_MACROS_SVH
`define SPRITE_QUAD_EXPANDER_MACROS_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define SQE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, off while rst_ni is low.
`define SQE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sqe_pkg.sv
// Shared constants, command/status types and tables of the sprite quad expander.
`timescale 1ns / 1ps
package sqe_pkg;

  localparam int unsigned MAX_SPRITES = 16384;
  localparam int unsigned CNT_W       = 15;
  localparam int unsigned VIDX_W      = 16;
  localparam int unsigned STEP_W      = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 48;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_FLUSH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPRITES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_UP    = 3'd4;

  localparam logic [CNT_W-1:0]      RST_MAX_SPRITES = 15'd16384;
  localparam logic [CFG_DATA_W-1:0] RST_BASIS_RIGHT = 48'd16384;
  localparam logic [CFG_DATA_W-1:0] RST_BASIS_UP    = 48'd1073741824;

  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN   = 34'sd2147483648;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Flush marker codes
  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_PRE  = 2'd1;
  localparam logic [1:0] MARK_POST = 2'd2;

  // Datapath operations
  localparam logic [3:0] OP_IDLE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_SQ       = 4'd2;
  localparam logic [3:0] OP_SQRT     = 4'd3;
  localparam logic [3:0] OP_DIV_GO   = 4'd4;
  localparam logic [3:0] OP_DIV_WAIT = 4'd5;
  localparam logic [3:0] OP_BASE     = 4'd6;
  localparam logic [3:0] OP_CORDIC   = 4'd7;
  localparam logic [3:0] OP_ROT      = 4'd8;
  localparam logic [3:0] OP_CORN     = 4'd9;
  localparam logic [3:0] OP_EMIT     = 4'd10;
  localparam logic [3:0] OP_DROP     = 4'd11;

  typedef struct packed {
    logic [3:0]        op;
    logic [STEP_W-1:0] step;
    logic              vsel;
    logic [VIDX_W-1:0] base;
    logic [1:0]        pre_mark;
    logic [1:0]        post_mark;
  } sqe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rot_zero;
    logic out_free;
  } sqe_stat_t;

  // CORDIC arctangent table, 2^32 units per turn
  function automatic logic signed [33:0] atan_val(input logic [3:0] i);
    logic signed [33:0] a;
    case (i)
      4'd0:    a = 34'sh020000000;
      4'd1:    a = 34'sh012E4051E;
      4'd2:    a = 34'sh009FB385B;
      4'd3:    a = 34'sh0051111D4;
      4'd4:    a = 34'sh0028B0D43;
      4'd5:    a = 34'sh00145D7E1;
      4'd6:    a = 34'sh000A2F61E;
      4'd7:    a = 34'sh000517C55;
      4'd8:    a = 34'sh00028BE53;
      4'd9:    a = 34'sh000145F2F;
      4'd10:   a = 34'sh0000A2F98;
      4'd11:   a = 34'sh0000517CC;
      4'd12:   a = 34'sh000028BE6;
      4'd13:   a = 34'sh0000145F3;
      4'd14:   a = 34'sh00000A2FA;
      default: a = 34'sh00000517D;
    endcase
    return a;
  endfunction

endpackage

>>> hw/rtl/sqe_div.sv
// Restoring divider, one quotient bit per cycle, for axis normalization.
`timescale 1ns / 1ps
module sqe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [46:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [30:0] quot_o
);

  localparam logic [4:0] LAST_BIT = 5'd30;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [15:0] rem_q;
  logic [30:0] nsh_q;
  logic [30:0] quot_q;
  logic [16:0] trial;
  logic        ge;
  logic [15:0] rem_d;

  always_comb begin
    trial = {rem_q, nsh_q[30]};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? 16'(trial - {1'b0, den_i}) : trial[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST_BIT);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LAST_BIT) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[46:31];
      nsh_q <= num_i[30:0];
    end else if (busy_q) begin
      rem_q  <= rem_d;
      nsh_q  <= {nsh_q[29:0], 1'b0};
      quot_q <= {quot_q[29:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> hw/rtl/sqe_dpath.sv
// Datapath: operand registers, shared multiplier, square root, divider, CORDIC and vertex output stage.
`timescale 1ns / 1ps
module sqe_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sqe_pkg::sqe_cmd_t   cmd_i,
  output sqe_pkg::sqe_stat_t  stat_o,
  input  logic                basis_mode_i,
  input  logic [47:0]         basis_right_i,
  input  logic [47:0]         basis_up_i,
  input  logic signed [31:0]  center_x_i,
  input  logic signed [31:0]  center_y_i,
  input  logic signed [31:0]  center_z_i,
  input  logic signed [31:0]  half_width_i,
  input  logic signed [31:0]  half_height_i,
  input  logic [31:0]         color_i,
  input  logic signed [31:0]  u_left_i,
  input  logic signed [31:0]  v_top_i,
  input  logic signed [31:0]  u_right_i,
  input  logic signed [31:0]  v_bottom_i,
  input  logic signed [15:0]  rotation_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic [31:0]         vertex_color_o,
  output logic signed [31:0]  tex_u_o,
  output logic signed [31:0]  tex_v_o,
  output logic [15:0]         vertex_index_o,
  output logic [1:0]          flush_marker_o,
  output logic                dropped_o,
  output logic                last_o
);

  function automatic logic signed [15:0] comp16(input logic [47:0] v, input logic [1:0] i);
    logic signed [15:0] c;
    case (i)
      2'd0:    c = v[15:0];
      2'd1:    c = v[31:16];
      default: c = v[47:32];
    endcase
    return c;
  endfunction

  function automatic logic signed [32:0] rnd30(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = (v + (68'sd1 <<< 29)) >>> 30;
    return t[32:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [69:0] v);
    logic [31:0] r;
    if (v > 70'sd2147483647)       r = 32'h7FFF_FFFF;
    else if (v < -70'sd2147483648) r = 32'h8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

  // Sprite operands
  logic signed [31:0] ctr_q [3];
  logic signed [31:0] hw_q, hh_q, ul_q, vt_q, ur_q, vb_q;
  logic [31:0]        col_q;
  logic signed [15:0] rot_q;

  // Arithmetic state
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod_q;
  logic [31:0]        sqn_q, root_q;
  logic signed [31:0] nrm_q [2][3];
  logic signed [32:0] rv_q [3];
  logic signed [32:0] uv_q [3];
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic signed [67:0] racc_q, uacc_q;
  logic signed [67:0] pq_q [6];

  // Output register
  logic               out_valid_q;
  logic               out_free;
  logic               out_load;

  logic [47:0]        vec;
  logic signed [15:0] vc;
  logic [15:0]        vmag;
  logic [15:0]        len;
  logic [46:0]        div_num;
  logic               div_done;
  logic [30:0]        div_quot;
  logic [30:0]        div_cap;
  logic signed [31:0] div_res;
  logic [31:0]        sq_bit, sq_trial;
  logic signed [33:0] cs, sn, z0, dx, dy;
  logic [4:0]         rj;
  logic [1:0]         ri;
  logic [2:0]         cj;
  logic [1:0]         k;
  logic               pos_r, pos_u;
  logic [31:0]        vpos [3];
  logic signed [69:0] acc [3];
  logic signed [69:0] pt, qt;

  assign vec  = cmd_i.vsel ? basis_up_i : basis_right_i;
  assign vc   = comp16(vec, cmd_i.step[1:0]);
  assign vmag = vc[15] ? (~vc + 16'd1) : vc;
  assign len  = root_q[15:0];
  assign div_num = {1'b0, vmag, 30'b0} + 47'(len >> 1);
  assign div_cap = (div_quot > 31'h4000_0000) ? 31'h4000_0000 : div_quot;
  assign div_res = (len == 16'd0) ? 32'sd0
                 : (vc[15] ? -$signed({1'b0, div_cap}) : $signed({1'b0, div_cap}));

  assign sq_bit   = 32'd1 << (5'd30 - {cmd_i.step[3:0], 1'b0});
  assign sq_trial = root_q + sq_bit;

  assign cs = flip_q ? -cx_q : cx_q;
  assign sn = flip_q ? -cy_q : cy_q;
  assign z0 = {{2{rot_q[15]}}, rot_q, 16'b0};
  assign dx = cy_q >>> cmd_i.step[3:0];
  assign dy = cx_q >>> cmd_i.step[3:0];

  assign rj = cmd_i.step - 5'd1;
  assign ri = rj[3:2];
  assign cj = rj[2:0];
  assign k  = cmd_i.step[1:0];

  sqe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == sqe_pkg::OP_DIV_GO),
    .num_i   (div_num),
    .den_i   (len),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.op)
      sqe_pkg::OP_SQ: begin
        ma = 34'(vc);
        mb = 34'(vc);
      end
      sqe_pkg::OP_ROT: begin
        if (cmd_i.step < 5'd12) begin
          case (cmd_i.step[1:0])
            2'd0:    begin ma = 34'(rv_q[cmd_i.step[3:2]]); mb = cs; end
            2'd1:    begin ma = 34'(uv_q[cmd_i.step[3:2]]); mb = sn; end
            2'd2:    begin ma = 34'(uv_q[cmd_i.step[3:2]]); mb = cs; end
            default: begin ma = 34'(rv_q[cmd_i.step[3:2]]); mb = sn; end
          endcase
        end
      end
      sqe_pkg::OP_CORN: begin
        if (cmd_i.step < 5'd3) begin
          ma = 34'(rv_q[cmd_i.step[1:0]]);
          mb = 34'(hw_q);
        end else if (cmd_i.step < 5'd6) begin
          ma = 34'(uv_q[2'(cmd_i.step - 5'd3)]);
          mb = 34'(hh_q);
        end
      end
      default: ;
    endcase
  end

  // Corner positions for the vertex in flight
  assign pos_r = (k == 2'd1) || (k == 2'd2);
  assign pos_u = k[1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt      = 70'(pq_q[i]);
      qt      = 70'(pq_q[3 + i]);
      acc[i]  = (70'(ctr_q[i]) <<< 30) + (pos_r ? pt : -pt) + (pos_u ? qt : -qt);
      vpos[i] = sat32((acc[i] + (70'sd1 <<< 29)) >>> 30);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free &&
                    ((cmd_i.op == sqe_pkg::OP_EMIT) || (cmd_i.op == sqe_pkg::OP_DROP));

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;

    unique case (cmd_i.op)
      sqe_pkg::OP_LOAD: begin
        ctr_q[0] <= center_x_i;
        ctr_q[1] <= center_y_i;
        ctr_q[2] <= center_z_i;
        hw_q  <= half_width_i;
        hh_q  <= half_height_i;
        col_q <= color_i;
        ul_q  <= u_left_i;
        vt_q  <= v_top_i;
        ur_q  <= u_right_i;
        vb_q  <= v_bottom_i;
        rot_q <= rotation_i;
      end
      sqe_pkg::OP_SQ: begin
        if (cmd_i.step == '0) begin
          sqn_q  <= '0;
          root_q <= '0;
        end else begin
          sqn_q <= sqn_q + prod_q[31:0];
        end
      end
      sqe_pkg::OP_SQRT: begin
        if (sqn_q >= sq_trial) begin
          sqn_q  <= sqn_q - sq_trial;
          root_q <= (root_q >> 1) + sq_bit;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      sqe_pkg::OP_DIV_WAIT: begin
        if (div_done) nrm_q[cmd_i.vsel][cmd_i.step[1:0]] <= div_res;
      end
      sqe_pkg::OP_BASE: begin
        for (int i = 0; i < 3; i++) begin
          if (basis_mode_i) begin
            rv_q[i] <= (i == 0) ? 33'(sqe_pkg::ONE_Q30) : 33'sd0;
            uv_q[i] <= (i == 1) ? 33'(sqe_pkg::ONE_Q30) : 33'sd0;
          end else begin
            rv_q[i] <= 33'(nrm_q[0][i]);
            uv_q[i] <= 33'(nrm_q[1][i]);
          end
        end
        cx_q <= sqe_pkg::CORDIC_GAIN;
        cy_q <= '0;
        // Fold angles past a quarter turn by a half turn; negate at the end
        if (z0 > sqe_pkg::ONE_Q30) begin
          cz_q   <= z0 - sqe_pkg::HALF_TURN;
          flip_q <= 1'b1;
        end else if (z0 < -sqe_pkg::ONE_Q30) begin
          cz_q   <= z0 + sqe_pkg::HALF_TURN;
          flip_q <= 1'b1;
        end else begin
          cz_q   <= z0;
          flip_q <= 1'b0;
        end
      end
      sqe_pkg::OP_CORDIC: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - sqe_pkg::atan_val(cmd_i.step[3:0]);
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + sqe_pkg::atan_val(cmd_i.step[3:0]);
        end
      end
      sqe_pkg::OP_ROT: begin
        if (cmd_i.step != '0) begin
          case (rj[1:0])
            2'd0: racc_q <= prod_q;
            2'd1: racc_q <= racc_q + prod_q;
            2'd2: uacc_q <= prod_q;
            default: begin
              rv_q[ri] <= rnd30(racc_q);
              uv_q[ri] <= rnd30(uacc_q - prod_q);
            end
          endcase
        end
      end
      sqe_pkg::OP_CORN: begin
        if (cmd_i.step != '0) pq_q[cj] <= prod_q;
      end
      default: ;
    endcase

    if (out_load) begin
      if (cmd_i.op == sqe_pkg::OP_DROP) begin
        pos_x_o        <= '0;
        pos_y_o        <= '0;
        pos_z_o        <= '0;
        vertex_color_o <= '0;
        tex_u_o        <= '0;
        tex_v_o        <= '0;
        vertex_index_o <= '0;
        flush_marker_o <= sqe_pkg::MARK_NONE;
        dropped_o      <= 1'b1;
        last_o         <= 1'b1;
      end else begin
        pos_x_o        <= vpos[0];
        pos_y_o        <= vpos[1];
        pos_z_o        <= vpos[2];
        vertex_color_o <= col_q;
        tex_u_o        <= (k == 2'd0 || k == 2'd3) ? ul_q : ur_q;
        tex_v_o        <= k[1] ? vt_q : vb_q;
        vertex_index_o <= cmd_i.base + 16'(k);
        flush_marker_o <= (k == 2'd0) ? cmd_i.pre_mark
                        : ((k == 2'd3) ? cmd_i.post_mark : sqe_pkg::MARK_NONE);
        dropped_o      <= 1'b0;
        last_o         <= (k == 2'd3);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.div_done = div_done;
  assign stat_o.rot_zero = (rot_q == 16'sd0);
  assign stat_o.out_free = out_free;

endmodule

>>> hw/rtl/sqe_ctrl.sv
// Controller: sprite sequencing, batch count and normalized-basis bookkeeping.
`timescale 1ns / 1ps
`include "sprite_quad_expander_macros.svh"
module sqe_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        basis_mode_i,
  input  logic                        auto_flush_i,
  input  logic [sqe_pkg::CNT_W-1:0]   max_sprites_i,
  input  logic                        basis_wr_i,
  input  sqe_pkg::sqe_stat_t          stat_i,
  output sqe_pkg::sqe_cmd_t           cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_SQRT   = 4'd2;
  localparam logic [3:0] S_DIVGO  = 4'd3;
  localparam logic [3:0] S_DIVW   = 4'd4;
  localparam logic [3:0] S_BASE   = 4'd5;
  localparam logic [3:0] S_CORDIC = 4'd6;
  localparam logic [3:0] S_ROT    = 4'd7;
  localparam logic [3:0] S_CORN   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;
  localparam logic [3:0] S_DROP   = 4'd10;

  localparam logic [sqe_pkg::CNT_W-1:0] CAP_MAX = sqe_pkg::CNT_W'(sqe_pkg::MAX_SPRITES);

  logic [3:0]                  state_q, state_d;
  logic [sqe_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        vsel_q, vsel_d;
  logic [sqe_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        norm_ok_q, norm_ok_d;
  logic [sqe_pkg::VIDX_W-1:0]  base_q, base_d;
  logic [1:0]                  pre_q, pre_d;
  logic [1:0]                  post_q, post_d;

  logic [sqe_pkg::CNT_W-1:0]   cap;
  logic                        full;
  logic                        drop;
  logic [sqe_pkg::CNT_W-1:0]   cnt_eff;
  logic [sqe_pkg::CNT_W-1:0]   cnt_inc;

  // Batch bookkeeping for the sprite at the input
  always_comb begin
    if (max_sprites_i == '0)         cap = sqe_pkg::CNT_W'(1);
    else if (max_sprites_i > CAP_MAX) cap = CAP_MAX;
    else                              cap = max_sprites_i;
    full    = count_q >= cap;
    drop    = full && !(auto_flush_i && (count_q != '0));
    cnt_eff = full ? '0 : count_q;
    cnt_inc = cnt_eff + sqe_pkg::CNT_W'(1);
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    vsel_d    = vsel_q;
    count_d   = count_q;
    norm_ok_d = norm_ok_q;
    base_d    = base_q;
    pre_d     = pre_q;
    post_d    = post_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (drop) begin
            state_d = S_DROP;
          end else begin
            base_d = {cnt_eff[13:0], 2'b00};
            pre_d  = full ? sqe_pkg::MARK_PRE : sqe_pkg::MARK_NONE;
            if (auto_flush_i && (cnt_inc >= cap)) begin
              count_d = '0;
              post_d  = sqe_pkg::MARK_POST;
            end else begin
              count_d = cnt_inc;
              post_d  = sqe_pkg::MARK_NONE;
            end
            step_d  = '0;
            vsel_d  = 1'b0;
            state_d = (!basis_mode_i && !norm_ok_q) ? S_SQ : S_BASE;
          end
        end
      end
      S_SQ: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd3) begin
          step_d  = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) begin
          step_d  = '0;
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: state_d = S_DIVW;
      S_DIVW: begin
        if (stat_i.div_done) begin
          if (step_q == 5'd2) begin
            step_d = '0;
            if (!vsel_q) begin
              vsel_d  = 1'b1;
              state_d = S_SQ;
            end else begin
              norm_ok_d = 1'b1;
              state_d   = S_BASE;
            end
          end else begin
            step_d  = step_q + 5'd1;
            state_d = S_DIVGO;
          end
        end
      end
      S_BASE: begin
        step_d  = '0;
        state_d = stat_i.rot_zero ? S_CORN : S_CORDIC;
      end
      S_CORDIC: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) begin
          step_d  = '0;
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd12) begin
          step_d  = '0;
          state_d = S_CORN;
        end
      end
      S_CORN: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd6) begin
          step_d  = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          step_d = step_q + 5'd1;
          if (step_q == 5'd3) begin
            step_d  = '0;
            state_d = S_IDLE;
          end
        end
      end
      S_DROP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // A new camera basis invalidates the cached unit axes
    if (basis_wr_i) norm_ok_d = 1'b0;
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:   cmd_o.op = in_valid_i ? sqe_pkg::OP_LOAD : sqe_pkg::OP_IDLE;
      S_SQ:     cmd_o.op = sqe_pkg::OP_SQ;
      S_SQRT:   cmd_o.op = sqe_pkg::OP_SQRT;
      S_DIVGO:  cmd_o.op = sqe_pkg::OP_DIV_GO;
      S_DIVW:   cmd_o.op = sqe_pkg::OP_DIV_WAIT;
      S_BASE:   cmd_o.op = sqe_pkg::OP_BASE;
      S_CORDIC: cmd_o.op = sqe_pkg::OP_CORDIC;
      S_ROT:    cmd_o.op = sqe_pkg::OP_ROT;
      S_CORN:   cmd_o.op = sqe_pkg::OP_CORN;
      S_EMIT:   cmd_o.op = sqe_pkg::OP_EMIT;
      S_DROP:   cmd_o.op = sqe_pkg::OP_DROP;
      default:  cmd_o.op = sqe_pkg::OP_IDLE;
    endcase
    cmd_o.step      = step_q;
    cmd_o.vsel      = vsel_q;
    cmd_o.base      = base_q;
    cmd_o.pre_mark  = pre_q;
    cmd_o.post_mark = post_q;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      vsel_q    <= 1'b0;
      count_q   <= '0;
      norm_ok_q <= 1'b0;
      base_q    <= '0;
      pre_q     <= sqe_pkg::MARK_NONE;
      post_q    <= sqe_pkg::MARK_NONE;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      vsel_q    <= vsel_d;
      count_q   <= count_d;
      norm_ok_q <= norm_ok_d;
      base_q    <= base_d;
      pre_q     <= pre_d;
      post_q    <= post_d;
    end
  end

  `SQE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_MAX, "sprite count above batch limit")
  `SQE_ASSERT_NEXT(a_drop_path, (state_q == S_IDLE) && in_valid_i && drop, state_q == S_DROP, "full batch sprite not dropped")
  `SQE_ASSERT_NEXT(a_emit_end, (state_q == S_EMIT) && stat_i.out_free && (step_q == 5'd3), state_q == S_IDLE, "sprite did not end after four vertices")

endmodule

>>> hw/rtl/sprite_quad_expander.sv
// Top level of the sprite quad expander: register file, controller and datapath.
`timescale 1ns / 1ps
// Each accepted sprite becomes four vertex beats (BL, BR, TR, TL), or a single
// beat with dropped set when the batch is full and auto flush is off. Sprites are
// handled one at a time. A sprite with nonzero rotation runs 16 CORDIC
// iterations, then 12 rotation and 6 corner products on the one shared 34x34
// multiplier, then 4 output beats; a sprite with zero rotation skips the
// CORDIC and rotation steps. With basis_mode 0, the first sprite after reset
// or after a write of basis_right or basis_up also normalizes both camera
// axes and caches them (16-step square root and three 31-step divisions per
// axis). The output register lets the last vertex wait on out_stall_i while
// the next sprite is accepted. Write configuration only while the block is
// idle.
module sprite_quad_expander (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sqe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sqe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [31:0]               center_x_i,
  input  logic signed [31:0]               center_y_i,
  input  logic signed [31:0]               center_z_i,
  input  logic signed [31:0]               half_width_i,
  input  logic signed [31:0]               half_height_i,
  input  logic [31:0]                      color_i,
  input  logic signed [31:0]               u_left_i,
  input  logic signed [31:0]               v_top_i,
  input  logic signed [31:0]               u_right_i,
  input  logic signed [31:0]               v_bottom_i,
  input  logic signed [15:0]               rotation_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [31:0]               pos_x_o,
  output logic signed [31:0]               pos_y_o,
  output logic signed [31:0]               pos_z_o,
  output logic [31:0]                      vertex_color_o,
  output logic signed [31:0]               tex_u_o,
  output logic signed [31:0]               tex_v_o,
  output logic [15:0]                      vertex_index_o,
  output logic [1:0]                       flush_marker_o,
  output logic                             dropped_o,
  output logic                             last_o
);

  logic                               basis_mode_q;
  logic                               auto_flush_q;
  logic [sqe_pkg::CNT_W-1:0]          max_sprites_q;
  logic [sqe_pkg::CFG_DATA_W-1:0]     basis_right_q;
  logic [sqe_pkg::CFG_DATA_W-1:0]     basis_up_q;
  logic                               basis_wr;
  sqe_pkg::sqe_cmd_t                  cmd;
  sqe_pkg::sqe_stat_t                 stat;

  // Register file; writes to unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_mode_q  <= 1'b0;
      auto_flush_q  <= 1'b1;
      max_sprites_q <= sqe_pkg::RST_MAX_SPRITES;
      basis_right_q <= sqe_pkg::RST_BASIS_RIGHT;
      basis_up_q    <= sqe_pkg::RST_BASIS_UP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sqe_pkg::CFG_BASIS_MODE:  basis_mode_q  <= cfg_data_i[0];
        sqe_pkg::CFG_AUTO_FLUSH:  auto_flush_q  <= cfg_data_i[0];
        sqe_pkg::CFG_MAX_SPRITES: max_sprites_q <= cfg_data_i[sqe_pkg::CNT_W-1:0];
        sqe_pkg::CFG_BASIS_RIGHT: basis_right_q <= cfg_data_i;
        sqe_pkg::CFG_BASIS_UP:    basis_up_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flag camera basis writes so the cached unit axes get recomputed
  assign basis_wr = cfg_we_i && ((cfg_idx_i == sqe_pkg::CFG_BASIS_RIGHT) ||
                                 (cfg_idx_i == sqe_pkg::CFG_BASIS_UP));

  sqe_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .basis_mode_i  (basis_mode_q),
    .auto_flush_i  (auto_flush_q),
    .max_sprites_i (max_sprites_q),
    .basis_wr_i    (basis_wr),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  sqe_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .basis_mode_i   (basis_mode_q),
    .basis_right_i  (basis_right_q),
    .basis_up_i     (basis_up_q),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .center_z_i     (center_z_i),
    .half_width_i   (half_width_i),
    .half_height_i  (half_height_i),
    .color_i        (color_i),
    .u_left_i       (u_left_i),
    .v_top_i        (v_top_i),
    .u_right_i      (u_right_i),
    .v_bottom_i     (v_bottom_i),
    .rotation_i     (rotation_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .vertex_color_o (vertex_color_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .vertex_index_o (vertex_index_o),
    .flush_marker_o (flush_marker_o),
    .dropped_o      (dropped_o),
    .last_o         (last_o)
  );

endmodule

>>> tb/tb_sprite_quad_expander.sv
// Self-checking testbench for the sprite quad expander.
`timescale 1ns / 1ps
module tb_sprite_quad_expander;

  // Run limit in cycles. It is far above the slowest legal run: about 480
  // sprites, a stall burst on every beat, an idle gap before every sprite,
  // and an axis normalization per phase.
  localparam int RUN_LIMIT   = 400000;
  localparam int DRAIN_WAIT  = 60;    // settle time after the last expected vertex
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off

  // One sprite beat on the input channel.
  typedef struct packed {
    logic signed [31:0] cx, cy, cz, hw, hh;
    logic [31:0]        color;
    logic signed [31:0] ul, vt, ur, vb;
    logic signed [15:0] rot;
  } sprite_t;

  // One vertex beat on the output channel.
  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic [31:0]        color;
    logic signed [31:0] tu, tv;
    logic [15:0]        vidx;
    logic [1:0]         mark;
    logic               dropped;
    logic               last;
  } vertex_t;

  // CORDIC arctangents, 2^32 units per turn
  localparam longint ATAN [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D};
  localparam longint Q30 = 64'sd1073741824;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [sqe_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [sqe_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  sprite_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vertex_t got;

  // Shadow copy of the configuration and the batch counter
  logic        sh_basis_mode = 1'b0;
  logic        sh_auto_flush = 1'b1;
  logic [14:0] sh_max_sprites = sqe_pkg::RST_MAX_SPRITES;
  logic [47:0] sh_basis_right = sqe_pkg::RST_BASIS_RIGHT;
  logic [47:0] sh_basis_up = sqe_pkg::RST_BASIS_UP;
  logic [14:0] batch_count = '0;

  vertex_t vertex_q[$];
  int errors = 0;
  int cycles = 0;
  bit sender_idle_en = 1'b1;
  bit receiver_idle_en = 1'b1;
  bit hold_req = 1'b0;

  sprite_quad_expander dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .center_x_i    (drv.cx),
    .center_y_i    (drv.cy),
    .center_z_i    (drv.cz),
    .half_width_i  (drv.hw),
    .half_height_i (drv.hh),
    .color_i       (drv.color),
    .u_left_i      (drv.ul),
    .v_top_i       (drv.vt),
    .u_right_i     (drv.ur),
    .v_bottom_i    (drv.vb),
    .rotation_i    (drv.rot),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pos_x_o       (got.px),
    .pos_y_o       (got.py),
    .pos_z_o       (got.pz),
    .vertex_color_o(got.color),
    .tex_u_o       (got.tu),
    .tex_v_o       (got.tv),
    .vertex_index_o(got.vidx),
    .flush_marker_o(got.mark),
    .dropped_o     (got.dropped),
    .last_o        (got.last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort on a hang: the handshake never completes or results stop coming.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex predictor
  // ---------------------------------------------------------------------------

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Normalize a packed Q2.14 vector into Q1.30 components; zero stays zero.
  task automatic normalize_axis(input logic [47:0] packed_v, output longint o[3]);
    longint c[3];
    longint unsigned sq, len, mag;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($signed(packed_v[16*i +: 16]));
      sq += longint'(c[i] * c[i]);
    end
    if (sq == 0) begin
      o = '{0, 0, 0};
      return;
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      mag = (c[i] < 0) ? -c[i] : c[i];
      mag = ((mag << 30) + len / 2) / len;
      if (mag > Q30) mag = Q30;
      o[i] = (c[i] < 0) ? -longint'(mag) : longint'(mag);
    end
  endtask

  // Sine and cosine in Q1.30 by 16 CORDIC iterations, folded past a quarter turn.
  task automatic cordic_sincos(input longint ang, output longint cs, output longint sn);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang * 65536;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > Q30) begin
      z -= 64'sd1 << 31;
      flip = 1'b1;
    end else if (z < -Q30) begin
      z += 64'sd1 << 31;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  function automatic logic signed [31:0] round_sat(input logic signed [95:0] acc);
    logic signed [95:0] v;
    v = (acc + (96'sd1 <<< 29)) >>> 30;
    if (v > 96'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -96'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Work out the vertex beats of one accepted sprite and queue them.
  task automatic expand_sprite(input sprite_t s);
    logic [14:0] cap;
    longint r[3], u[3], cs, sn, r0, u0;
    logic [1:0] pre_mark, post_mark;
    logic [15:0] base;
    vertex_t v;
    logic signed [95:0] acc;
    logic signed [31:0] ctr[3];
    int sgn_r, sgn_u;
    cap = (sh_max_sprites == 0) ? 15'd1 :
          (sh_max_sprites > sqe_pkg::MAX_SPRITES) ? 15'(sqe_pkg::MAX_SPRITES)
                                                  : sh_max_sprites;
    pre_mark = sqe_pkg::MARK_NONE;
    post_mark = sqe_pkg::MARK_NONE;
    if (batch_count >= cap) begin
      if (sh_auto_flush && batch_count != 0) begin
        batch_count = '0;
        pre_mark = sqe_pkg::MARK_PRE;
      end else begin
        // Batch full with no auto flush: one zeroed beat flagged as dropped
        v = '0;
        v.dropped = 1'b1;
        v.last = 1'b1;
        vertex_q.push_back(v);
        return;
      end
    end
    if (sh_basis_mode) begin
      r = '{Q30, 0, 0};
      u = '{0, Q30, 0};
    end else begin
      normalize_axis(sh_basis_right, r);
      normalize_axis(sh_basis_up, u);
    end
    if (s.rot != 0) begin
      cordic_sincos(longint'(s.rot), cs, sn);
      for (int i = 0; i < 3; i++) begin
        r0 = r[i];
        u0 = u[i];
        r[i] = (r0 * cs + u0 * sn + (64'sd1 << 29)) >>> 30;
        u[i] = (u0 * cs - r0 * sn + (64'sd1 << 29)) >>> 30;
      end
    end
    ctr = '{s.cx, s.cy, s.cz};
    base = {batch_count[13:0], 2'b00};
    batch_count = batch_count + 15'd1;
    if (sh_auto_flush && batch_count >= cap) begin
      batch_count = '0;
      post_mark = sqe_pkg::MARK_POST;
    end
    // Corners in order BL, BR, TR, TL
    for (int k = 0; k < 4; k++) begin
      sgn_r = (k == 0 || k == 3) ? -1 : 1;
      sgn_u = (k < 2) ? -1 : 1;
      v = '0;
      for (int i = 0; i < 3; i++) begin
        acc = (96'(ctr[i]) <<< 30)
            + 96'(sgn_r) * 96'(r[i]) * 96'(s.hw)
            + 96'(sgn_u) * 96'(u[i]) * 96'(s.hh);
        case (i)
          0: v.px = round_sat(acc);
          1: v.py = round_sat(acc);
          default: v.pz = round_sat(acc);
        endcase
      end
      v.color = s.color;
      v.tu = (k == 0 || k == 3) ? s.ul : s.ur;
      v.tv = (k < 2) ? s.vb : s.vt;
      v.vidx = base + 16'(k);
      v.mark = (k == 0) ? pre_mark : ((k == 3) ? post_mark : sqe_pkg::MARK_NONE);
      v.last = (k == 3);
      vertex_q.push_back(v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers and result checker
  // ---------------------------------------------------------------------------

  // Write one register; the block must be idle.
  task automatic write_reg(input logic [sqe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [47:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      sqe_pkg::CFG_BASIS_MODE:  sh_basis_mode = data[0];
      sqe_pkg::CFG_AUTO_FLUSH:  sh_auto_flush = data[0];
      sqe_pkg::CFG_MAX_SPRITES: sh_max_sprites = data[14:0];
      sqe_pkg::CFG_BASIS_RIGHT: sh_basis_right = data;
      sqe_pkg::CFG_BASIS_UP:    sh_basis_up = data;
      default: ;
    endcase
  endtask

  // Offer one sprite beat and hold it until accepted; predict on acceptance.
  task automatic send_sprite(input sprite_t s);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    drv = s;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expand_sprite(s);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait until every expected vertex has arrived, then let the block settle.
  task automatic drain;
    wait (vertex_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Receiver: random stall bursts, or one long hold-off on request.
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_stall = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
      out_stall = 1'b0;
    end else if (receiver_idle_en && $urandom_range(0, 3) == 0) begin
      out_stall = 1'b1;
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each accepted vertex beat with the oldest prediction.
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex beat: %p", got);
      end else begin
        want = vertex_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("vertex mismatch at cycle %0d", cycles);
            $display("  exp: %p", want);
            $display("  got: %p", got);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Q16.16 value biased toward the interesting corners.
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return $urandom();
      default: return 32'($signed(21'($urandom())));  // moderate, rarely saturates
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'h0;
      1: return 16'h8000;
      2: return 16'h4000 + 16'($urandom_range(0, 2)) - 16'd1;
      3: return 16'hC000 + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.cx = pick_q16();
    s.cy = pick_q16();
    s.cz = pick_q16();
    s.hw = pick_q16();
    s.hh = pick_q16();
    s.color = $urandom();
    s.ul = $urandom();
    s.vt = $urandom();
    s.ur = $urandom();
    s.vb = $urandom();
    s.rot = pick_angle();
    return s;
  endfunction

  function automatic logic [47:0] random_axis();
    case ($urandom_range(0, 5))
      0: return 48'h0;
      1: return {16'($urandom()), $urandom()};
      2: return {16'($signed(8'($urandom()))), 16'($signed(8'($urandom()))),
                 16'($signed(8'($urandom())))};
      default: return {16'($signed(15'($urandom()))), 16'($signed(15'($urandom()))),
                       16'($signed(15'($urandom())))};
    endcase
  endfunction

  function automatic sprite_t make_sprite(input logic [31:0] c, input logic [31:0] h,
                                          input logic [15:0] rot);
    sprite_t s;
    s = random_sprite();
    s.cx = c; s.cy = c; s.cz = c;
    s.hw = h; s.hh = h;
    s.rot = rot;
    return s;
  endfunction

  // Reset configuration: field extremes and the rotation folds.
  task automatic test_reset_config;
    sprite_t s;
    send_sprite(make_sprite(32'h0, 32'h00010000, 16'h0));      // no rotation
    send_sprite(make_sprite(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0)); // saturate high
    send_sprite(make_sprite(32'h80000000, 32'h7FFFFFFF, 16'h8000)); // saturate low
    send_sprite(make_sprite(32'h00100000, 32'h80000000, 16'h4000));
    send_sprite(make_sprite(32'hFFF00000, 32'h00020000, 16'h4001));
    s = make_sprite(32'h12345678, 32'h00008000, 16'hBFFF);
    s.color = 32'hFFFFFFFF;
    s.ul = 32'h80000000; s.ur = 32'h7FFFFFFF;
    s.vt = 32'h7FFFFFFF; s.vb = 32'h80000000;
    send_sprite(s);
    send_sprite(make_sprite(32'h0, 32'h00010000, 16'h7FFF));
    drain();
  endtask

  // Fixed world basis.
  task automatic test_world_basis;
    write_reg(sqe_pkg::CFG_BASIS_MODE, 48'd1);
    send_sprite(make_sprite(32'h00050000, 32'h00030000, 16'h0));
    send_sprite(make_sprite(32'h00050000, 32'h00030000, 16'h2000));
    send_sprite(make_sprite(32'hFFFB0000, 32'h00030000, 16'h8000));
    send_sprite(make_sprite(32'h0, 32'h7FFFFFFF, 16'hC001));
    drain();
  endtask

  // Zero length axis, dropping on a full batch, and out of range batch sizes.
  task automatic test_batch_limits;
    write_reg(sqe_pkg::CFG_BASIS_MODE, 48'd0);
    write_reg(sqe_pkg::CFG_BASIS_RIGHT, 48'h0);
    write_reg(sqe_pkg::CFG_BASIS_UP, 48'h0000_2000_C000);
    write_reg(sqe_pkg::CFG_AUTO_FLUSH, 48'd0);
    write_reg(sqe_pkg::CFG_MAX_SPRITES, 48'd2);
    repeat (4) send_sprite(make_sprite(32'h00010000, 32'h00010000, 16'h1000));
    drain();
    write_reg(sqe_pkg::CFG_AUTO_FLUSH, 48'd1);
    write_reg(sqe_pkg::CFG_MAX_SPRITES, 48'd0);  // acts as one sprite per batch
    repeat (3) send_sprite(random_sprite());
    drain();
    write_reg(sqe_pkg::CFG_MAX_SPRITES, 48'h7FFF);  // clamps to the largest batch
    send_sprite(random_sprite());
    drain();
  endtask

  // Random phases over a spread of settings; one phase with a long hold-off.
  task automatic test_random;
    logic [14:0] sizes[8];
    sizes = '{15'd0, 15'd1, 15'd2, 15'd3, 15'd5, 15'd16384, 15'h7FFF, 15'd7};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(sqe_pkg::CFG_BASIS_MODE, 48'($urandom_range(0, 2) == 0));
      write_reg(sqe_pkg::CFG_AUTO_FLUSH, 48'($urandom_range(0, 3) != 0));
      write_reg(sqe_pkg::CFG_MAX_SPRITES, 48'(sizes[ph]));
      write_reg(sqe_pkg::CFG_BASIS_RIGHT, random_axis());
      write_reg(sqe_pkg::CFG_BASIS_UP, random_axis());
      if (ph == 6) begin
        sender_idle_en = 1'b0;
        receiver_idle_en = 1'b0;
      end
      if (ph == 2) hold_req = 1'b1;
      repeat (64) send_sprite(random_sprite());
      drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_config();
    test_world_basis();
    test_batch_limits();
    test_random();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sqe_pkg.sv
hw/rtl/sqe_div.sv
hw/rtl/sqe_dpath.sv
hw/rtl/sqe_ctrl.sv
hw/rtl/sprite_quad_expander.sv
tb/tb_sprite_quad_expander.sv
